// ----- src/dcr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dcr_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int ADDR_BITS    = 16;
    localparam int CH_BITS      = $clog2(NUM_CHANNELS);
    localparam int COUNT_BITS   = 16;
    localparam int MODE_BITS    = 6;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_STEP  = 2'd2,
        OP_NOP   = 2'd3
    } dcr_op_t;

    localparam logic [3:0] REG_CMD_STATUS  = 4'd8;
    localparam logic [3:0] REG_REQUEST     = 4'd9;
    localparam logic [3:0] REG_SINGLE_MASK = 4'd10;
    localparam logic [3:0] REG_MODE        = 4'd11;
    localparam logic [3:0] REG_CLEAR_FF    = 4'd12;
    localparam logic [3:0] REG_MASTER_CLR  = 4'd13;
    localparam logic [3:0] REG_CLEAR_MASK  = 4'd14;
    localparam logic [3:0] REG_WRITE_MASK  = 4'd15;

    // command byte bit 2 disables the controller
    localparam int CMD_DISABLE_BIT    = 2;
    // data bit 2 of request and single-mask writes
    localparam int SET_BIT            = 2;
    // bits of the stored mode (mode byte shifted down by two)
    localparam int MODE_AUTOINIT_BIT  = 2;
    localparam int MODE_DECREMENT_BIT = 3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] reg_offset;
        logic [7:0] write_data;
        logic [1:0] channel;
    } dcr_in_t;

    typedef struct packed {
        logic [7:0]           read_data;
        logic [ADDR_BITS-1:0] xfer_address;
        logic                 xfer_done;
        logic                 terminal_count;
    } dcr_out_t;

endpackage

`default_nettype wire

// ----- src/dma_controller_registers.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Four-channel 8237A-style DMA controller register file. Each request is a
// register write, a register read, one transfer step on a channel or a no-op,
// and gives exactly one response. Requests are registered on entry, executed
// against the controller state as they move to the response register, and
// one request can be taken every clock while the response is not stalled; a
// stalled response holds the next request in the input register. Reading the
// status register clears the terminal-count bits. All state resets to zero
// with every channel masked.
module dma_controller_registers (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire dcr_pkg::dcr_in_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output dcr_pkg::dcr_out_t  m_data
);
    import dcr_pkg::*;

    dcr_in_t  req_reg;
    logic     req_valid_reg;
    dcr_out_t rsp_next;
    dcr_out_t rsp_reg;
    logic     rsp_valid_reg;
    logic     advance;

    assign advance = req_valid_reg && (!rsp_valid_reg || m_ready);
    assign s_ready = !req_valid_reg || advance;
    assign m_valid = rsp_valid_reg;
    assign m_data  = rsp_reg;

    dcr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .exec    (advance),
        .req     (req_reg),
        .rsp     (rsp_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                req_valid_reg <= s_valid;
            end
            if (advance) begin
                rsp_valid_reg <= 1'b1;
            end else if (m_ready) begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            req_reg <= s_data;
        end
        if (advance) begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/dcr_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dcr_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           exec,
    input  wire dcr_pkg::dcr_in_t req,
    output dcr_pkg::dcr_out_t   rsp
);
    import dcr_pkg::*;

    logic [ADDR_BITS-1:0]  base_addr_reg  [NUM_CHANNELS];
    logic [ADDR_BITS-1:0]  base_addr_next [NUM_CHANNELS];
    logic [COUNT_BITS-1:0] base_cnt_reg   [NUM_CHANNELS];
    logic [COUNT_BITS-1:0] base_cnt_next  [NUM_CHANNELS];
    logic [ADDR_BITS-1:0]  cur_addr_reg   [NUM_CHANNELS];
    logic [ADDR_BITS-1:0]  cur_addr_next  [NUM_CHANNELS];
    logic [COUNT_BITS-1:0] cur_cnt_reg    [NUM_CHANNELS];
    logic [COUNT_BITS-1:0] cur_cnt_next   [NUM_CHANNELS];
    logic [MODE_BITS-1:0]  mode_reg       [NUM_CHANNELS];
    logic [MODE_BITS-1:0]  mode_next      [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] mask_reg, mask_next;
    logic [NUM_CHANNELS-1:0] tc_reg, tc_next;
    logic [NUM_CHANNELS-1:0] dreq_reg, dreq_next;
    logic [7:0]              cmd_reg, cmd_next;
    logic                    ff_reg, ff_next;

    logic [CH_BITS-1:0]    reg_ch;
    logic [CH_BITS-1:0]    data_ch;
    logic [CH_BITS-1:0]    step_ch;
    logic [ADDR_BITS-1:0]  rd_word;
    logic [ADDR_BITS-1:0]  step_addr;
    logic [COUNT_BITS-1:0] step_cnt;
    logic [MODE_BITS-1:0]  step_mode;

    assign reg_ch    = req.reg_offset[CH_BITS:1];
    assign data_ch   = req.write_data[CH_BITS-1:0];
    assign step_ch   = req.channel;
    assign step_addr = cur_addr_reg[step_ch];
    assign step_cnt  = cur_cnt_reg[step_ch];
    assign step_mode = mode_reg[step_ch];
    assign rd_word   = req.reg_offset[0] ? cur_cnt_reg[reg_ch] : cur_addr_reg[reg_ch];

    always_comb begin
        base_addr_next = base_addr_reg;
        base_cnt_next  = base_cnt_reg;
        cur_addr_next  = cur_addr_reg;
        cur_cnt_next   = cur_cnt_reg;
        mode_next      = mode_reg;
        mask_next      = mask_reg;
        tc_next        = tc_reg;
        dreq_next      = dreq_reg;
        cmd_next       = cmd_reg;
        ff_next        = ff_reg;
        rsp            = '0;

        case (dcr_op_t'(req.opcode))
            OP_WRITE: begin
                if (!req.reg_offset[3]) begin
                    if (req.reg_offset[0]) begin
                        if (ff_reg) begin
                            base_cnt_next[reg_ch][15:8] = req.write_data;
                            cur_cnt_next[reg_ch][15:8]  = req.write_data;
                        end else begin
                            base_cnt_next[reg_ch][7:0] = req.write_data;
                            cur_cnt_next[reg_ch][7:0]  = req.write_data;
                        end
                    end else begin
                        if (ff_reg) begin
                            base_addr_next[reg_ch][15:8] = req.write_data;
                            cur_addr_next[reg_ch][15:8]  = req.write_data;
                        end else begin
                            base_addr_next[reg_ch][7:0] = req.write_data;
                            cur_addr_next[reg_ch][7:0]  = req.write_data;
                        end
                    end
                    ff_next = ~ff_reg;
                end else begin
                    case (req.reg_offset)
                        REG_CMD_STATUS:  cmd_next = req.write_data;
                        REG_REQUEST:     dreq_next[data_ch] = req.write_data[SET_BIT];
                        REG_SINGLE_MASK: mask_next[data_ch] = req.write_data[SET_BIT];
                        REG_MODE:        mode_next[data_ch] = req.write_data[7:2];
                        REG_CLEAR_FF:    ff_next = 1'b0;
                        REG_MASTER_CLR: begin
                            cmd_next  = '0;
                            tc_next   = '0;
                            dreq_next = '0;
                            ff_next   = 1'b0;
                            mask_next = '1;
                        end
                        REG_CLEAR_MASK:  mask_next = '0;
                        REG_WRITE_MASK:  mask_next = req.write_data[NUM_CHANNELS-1:0];
                        default: ;
                    endcase
                end
            end
            OP_READ: begin
                if (!req.reg_offset[3]) begin
                    rsp.read_data = ff_reg ? rd_word[15:8] : rd_word[7:0];
                    ff_next       = ~ff_reg;
                end else if (req.reg_offset == REG_CMD_STATUS) begin
                    rsp.read_data = {dreq_reg, tc_reg};
                    tc_next       = '0;
                end
            end
            OP_STEP: begin
                if (!cmd_reg[CMD_DISABLE_BIT] && !mask_reg[step_ch]) begin
                    rsp.xfer_done    = 1'b1;
                    rsp.xfer_address = step_addr;
                    cur_addr_next[step_ch] = step_mode[MODE_DECREMENT_BIT] ?
                                             step_addr - ADDR_BITS'(1) :
                                             step_addr + ADDR_BITS'(1);
                    if (step_cnt == '0) begin
                        rsp.terminal_count = 1'b1;
                        tc_next[step_ch]   = 1'b1;
                        dreq_next[step_ch] = 1'b0;
                        if (step_mode[MODE_AUTOINIT_BIT]) begin
                            cur_addr_next[step_ch] = base_addr_reg[step_ch];
                            cur_cnt_next[step_ch]  = base_cnt_reg[step_ch];
                        end else begin
                            cur_cnt_next[step_ch] = '1;
                            mask_next[step_ch]    = 1'b1;
                        end
                    end else begin
                        cur_cnt_next[step_ch] = step_cnt - COUNT_BITS'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                base_addr_reg[i] <= '0;
                base_cnt_reg[i]  <= '0;
                cur_addr_reg[i]  <= '0;
                cur_cnt_reg[i]   <= '0;
                mode_reg[i]      <= '0;
            end
            mask_reg <= '1;
            tc_reg   <= '0;
            dreq_reg <= '0;
            cmd_reg  <= '0;
            ff_reg   <= 1'b0;
        end else if (exec) begin
            base_addr_reg <= base_addr_next;
            base_cnt_reg  <= base_cnt_next;
            cur_addr_reg  <= cur_addr_next;
            cur_cnt_reg   <= cur_cnt_next;
            mode_reg      <= mode_next;
            mask_reg      <= mask_next;
            tc_reg        <= tc_next;
            dreq_reg      <= dreq_next;
            cmd_reg       <= cmd_next;
            ff_reg        <= ff_next;
        end
    end

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import dcr_pkg::*;

    typedef struct {
        dcr_in_t  req;
        bit       typed;
        dcr_out_t want;
    } dir_row_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    dcr_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    dcr_out_t m_data;

    dcr_out_t pending_results [$];
    dir_row_t dir_rows [0:24];
    int       errors     = 0;
    int       items_sent = 0;
    bit       calm       = 1'b0;

    // controller state as predicted
    logic [15:0] base_addr [NUM_CHANNELS];
    logic [15:0] base_cnt  [NUM_CHANNELS];
    logic [15:0] cur_addr  [NUM_CHANNELS];
    logic [15:0] cur_cnt   [NUM_CHANNELS];
    logic [5:0]  chan_mode [NUM_CHANNELS];
    logic [3:0]  chan_mask;
    logic [3:0]  tc_bits;
    logic [3:0]  req_bits;
    logic [7:0]  cmd_byte;
    logic        flip_flop;

    dma_controller_registers dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [15:0] put_byte(logic [15:0] w, logic [7:0] b);
        return flip_flop ? {b, w[7:0]} : {w[15:8], b};
    endfunction

    function automatic dcr_out_t dma_step_result(dcr_in_t r);
        dcr_out_t    res;
        logic [1:0]  ch;
        logic [15:0] word;
        logic [7:0]  d;
        res = '0;
        d = r.write_data;
        case (r.opcode)
            OP_WRITE: begin
                if (r.reg_offset < REG_CMD_STATUS) begin
                    ch = r.reg_offset[2:1];
                    if (r.reg_offset[0]) begin
                        base_cnt[ch] = put_byte(base_cnt[ch], d);
                        cur_cnt[ch]  = put_byte(cur_cnt[ch], d);
                    end else begin
                        base_addr[ch] = put_byte(base_addr[ch], d);
                        cur_addr[ch]  = put_byte(cur_addr[ch], d);
                    end
                    flip_flop = ~flip_flop;
                end else begin
                    ch = d[1:0];
                    case (r.reg_offset)
                        REG_CMD_STATUS:  cmd_byte = d;
                        REG_REQUEST:     req_bits[ch] = d[SET_BIT];
                        REG_SINGLE_MASK: chan_mask[ch] = d[SET_BIT];
                        REG_MODE:        chan_mode[ch] = d[7:2];
                        REG_CLEAR_FF:    flip_flop = 1'b0;
                        REG_MASTER_CLR: begin
                            cmd_byte  = '0;
                            tc_bits   = '0;
                            req_bits  = '0;
                            flip_flop = 1'b0;
                            chan_mask = '1;
                        end
                        REG_CLEAR_MASK:  chan_mask = '0;
                        default:         chan_mask = d[3:0];
                    endcase
                end
            end
            OP_READ: begin
                if (r.reg_offset < REG_CMD_STATUS) begin
                    ch = r.reg_offset[2:1];
                    word = r.reg_offset[0] ? cur_cnt[ch] : cur_addr[ch];
                    res.read_data = flip_flop ? word[15:8] : word[7:0];
                    flip_flop = ~flip_flop;
                end else if (r.reg_offset == REG_CMD_STATUS) begin
                    res.read_data = {req_bits, tc_bits};
                    tc_bits = '0;
                end
            end
            OP_STEP: begin
                ch = r.channel;
                if (!cmd_byte[CMD_DISABLE_BIT] && !chan_mask[ch]) begin
                    res.xfer_done    = 1'b1;
                    res.xfer_address = cur_addr[ch];
                    if (chan_mode[ch][MODE_DECREMENT_BIT])
                        cur_addr[ch] = cur_addr[ch] - 16'd1;
                    else
                        cur_addr[ch] = cur_addr[ch] + 16'd1;
                    if (cur_cnt[ch] == 16'd0) begin
                        res.terminal_count = 1'b1;
                        tc_bits[ch]  = 1'b1;
                        req_bits[ch] = 1'b0;
                        if (chan_mode[ch][MODE_AUTOINIT_BIT]) begin
                            cur_addr[ch] = base_addr[ch];
                            cur_cnt[ch]  = base_cnt[ch];
                        end else begin
                            cur_cnt[ch]   = 16'hFFFF;
                            chan_mask[ch] = 1'b1;
                        end
                    end else begin
                        cur_cnt[ch] = cur_cnt[ch] - 16'd1;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic dcr_in_t mk_req(logic [1:0] op, logic [3:0] off, logic [7:0] d,
                                       logic [1:0] ch);
        dcr_in_t r;
        r.opcode     = op;
        r.reg_offset = off;
        r.write_data = d;
        r.channel    = ch;
        return r;
    endfunction

    function automatic dir_row_t mk_row(dcr_in_t r, bit typed, logic [7:0] rd,
                                        logic [15:0] xa, logic done, logic tc);
        dir_row_t row;
        row.req   = r;
        row.typed = typed;
        row.want  = '{read_data: rd, xfer_address: xa, xfer_done: done,
                      terminal_count: tc};
        return row;
    endfunction

    task automatic send_req(dcr_in_t r, bit typed, dcr_out_t want);
        int       gap;
        dcr_out_t predicted;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = dma_step_result(r);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic drain_requests();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // response side: random stalls per response
    initial begin
        int stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        dcr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected response, expected none got %h", $time, m_data);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.read_data !== want.read_data) begin
                    $display("%0t: read_data expected %h got %h", $time,
                             want.read_data, m_data.read_data);
                    errors++;
                end
                if (m_data.xfer_address !== want.xfer_address) begin
                    $display("%0t: xfer_address expected %h got %h", $time,
                             want.xfer_address, m_data.xfer_address);
                    errors++;
                end
                if (m_data.xfer_done !== want.xfer_done) begin
                    $display("%0t: xfer_done expected %b got %b", $time,
                             want.xfer_done, m_data.xfer_done);
                    errors++;
                end
                if (m_data.terminal_count !== want.terminal_count) begin
                    $display("%0t: terminal_count expected %b got %b", $time,
                             want.terminal_count, m_data.terminal_count);
                    errors++;
                end
            end
        end
    end

    initial begin
        #1000000;
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        int         k;
        int         n;
        logic [1:0] ch;
        logic [7:0] d;
        dcr_out_t   none;
        none = '0;
        for (k = 0; k < NUM_CHANNELS; k++) begin
            base_addr[k] = '0;
            base_cnt[k]  = '0;
            cur_addr[k]  = '0;
            cur_cnt[k]   = '0;
            chan_mode[k] = '0;
        end
        chan_mask = '1;
        tc_bits   = '0;
        req_bits  = '0;
        cmd_byte  = '0;
        flip_flop = 1'b0;

        dir_rows = '{
            mk_row(mk_req(OP_READ,  REG_CMD_STATUS,  8'h00, 2'd0), 1, 8'h00, 16'h0000, 0, 0),
            mk_row(mk_req(OP_READ,  4'd0,            8'h00, 2'd0), 1, 8'h00, 16'h0000, 0, 0),
            mk_row(mk_req(OP_READ,  REG_WRITE_MASK,  8'h00, 2'd0), 1, 8'h00, 16'h0000, 0, 0),
            mk_row(mk_req(OP_STEP,  4'd0,            8'h00, 2'd0), 1, 8'h00, 16'h0000, 0, 0),
            mk_row(mk_req(OP_NOP,   4'hF,            8'hFF, 2'd3), 1, 8'h00, 16'h0000, 0, 0),
            mk_row(mk_req(OP_WRITE, REG_CLEAR_FF,    8'h00, 2'd0), 0, 8'h00, 16'h0000, 0, 0),
            mk_row(mk_req(OP_WRITE, 4'd0,            8'hFF, 2'd0), 0, 8'h00, 16'h0000, 0, 0),
            mk_row(mk_req(OP_WRITE, 4'd0,            8'hFF, 2'd0), 0, 8'h00, 16'h0000, 0, 0),
            mk_row(mk_req(OP_WRITE, 4'd1,            8'h00, 2'd0), 0, 8'h00, 16'h0000, 0, 0),
            mk_row(mk_req(OP_WRITE, 4'd1,            8'h00, 2'd0), 0, 8'h00, 16'h0000, 0, 0),
            mk_row(mk_req(OP_WRITE, REG_MODE,        8'h10, 2'd0), 0, 8'h00, 16'h0000, 0, 0),
            mk_row(mk_req(OP_WRITE, REG_CLEAR_MASK,  8'h00, 2'd0), 0, 8'h00, 16'h0000, 0, 0),
            mk_row(mk_req(OP_STEP,  4'd0,            8'h00, 2'd0), 1, 8'h00, 16'hFFFF, 1, 1),
            mk_row(mk_req(OP_READ,  REG_CMD_STATUS,  8'h00, 2'd0), 1, 8'h01, 16'h0000, 0, 0),
            mk_row(mk_req(OP_WRITE, REG_REQUEST,     8'h06, 2'd0), 0, 8'h00, 16'h0000, 0, 0),
            mk_row(mk_req(OP_READ,  REG_CMD_STATUS,  8'h00, 2'd0), 1, 8'h40, 16'h0000, 0, 0),
            mk_row(mk_req(OP_WRITE, REG_MODE,        8'h23, 2'd0), 0, 8'h00, 16'h0000, 0, 0),
            mk_row(mk_req(OP_WRITE, REG_CMD_STATUS,  8'h04, 2'd0), 0, 8'h00, 16'h0000, 0, 0),
            mk_row(mk_req(OP_STEP,  4'd0,            8'h00, 2'd0), 1, 8'h00, 16'h0000, 0, 0),
            mk_row(mk_req(OP_WRITE, REG_CMD_STATUS,  8'h00, 2'd0), 0, 8'h00, 16'h0000, 0, 0),
            mk_row(mk_req(OP_STEP,  4'd0,            8'h00, 2'd3), 1, 8'h00, 16'h0000, 1, 1),
            mk_row(mk_req(OP_STEP,  4'd0,            8'h00, 2'd3), 1, 8'h00, 16'h0000, 0, 0),
            mk_row(mk_req(OP_WRITE, REG_SINGLE_MASK, 8'h04, 2'd0), 0, 8'h00, 16'h0000, 0, 0),
            mk_row(mk_req(OP_WRITE, REG_WRITE_MASK,  8'hF0, 2'd0), 0, 8'h00, 16'h0000, 0, 0),
            mk_row(mk_req(OP_WRITE, REG_MASTER_CLR,  8'hFF, 2'd0), 0, 8'h00, 16'h0000, 0, 0)
        };

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < 25; k++)
            send_req(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);
        drain_requests();

        while (items_sent < 1425) begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 6) begin
                // program one channel, run it, read it back
                ch = 2'($urandom_range(0, 3));
                send_req(mk_req(OP_WRITE, REG_CLEAR_FF, 8'($urandom), 2'($urandom)), 0, none);
                send_req(mk_req(OP_WRITE, {1'b0, ch, 1'b0}, 8'($urandom), 2'($urandom)), 0, none);
                send_req(mk_req(OP_WRITE, {1'b0, ch, 1'b0}, 8'($urandom), 2'($urandom)), 0, none);
                d = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
                send_req(mk_req(OP_WRITE, {1'b0, ch, 1'b1}, d, 2'($urandom)), 0, none);
                d = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00;
                send_req(mk_req(OP_WRITE, {1'b0, ch, 1'b1}, d, 2'($urandom)), 0, none);
                send_req(mk_req(OP_WRITE, REG_MODE, {6'($urandom), ch}, 2'($urandom)), 0, none);
                d = 8'($urandom);
                if ($urandom_range(0, 7) != 0)
                    d[CMD_DISABLE_BIT] = 1'b0;
                send_req(mk_req(OP_WRITE, REG_CMD_STATUS, d, 2'($urandom)), 0, none);
                if ($urandom_range(0, 3) == 0)
                    send_req(mk_req(OP_WRITE, REG_REQUEST, 8'($urandom), 2'($urandom)), 0,
                             none);
                case ($urandom_range(0, 2))
                    0: send_req(mk_req(OP_WRITE, REG_SINGLE_MASK,
                                       {3'($urandom), 3'b000, ch}, 2'($urandom)), 0, none);
                    1: send_req(mk_req(OP_WRITE, REG_CLEAR_MASK, 8'($urandom),
                                       2'($urandom)), 0, none);
                    default: send_req(mk_req(OP_WRITE, REG_WRITE_MASK, 8'($urandom),
                                             2'($urandom)), 0, none);
                endcase
                n = $urandom_range(1, 12);
                for (k = 0; k < n; k++) begin
                    send_req(mk_req(OP_STEP, 4'($urandom), 8'($urandom),
                                    ($urandom_range(0, 5) == 0) ? 2'($urandom) : ch), 0, none);
                    if ($urandom_range(0, 5) == 0)
                        send_req(mk_req(OP_READ, REG_CMD_STATUS, 8'($urandom),
                                        2'($urandom)), 0, none);
                end
                if ($urandom_range(0, 3) != 0)
                    send_req(mk_req(OP_WRITE, REG_CLEAR_FF, 8'($urandom), 2'($urandom)), 0,
                             none);
                for (k = 0; k < 4; k++)
                    send_req(mk_req(OP_READ, {1'b0, ch, k[1]}, 8'($urandom), 2'($urandom)),
                             0, none);
                send_req(mk_req(OP_READ, REG_CMD_STATUS, 8'($urandom), 2'($urandom)), 0, none);
            end else begin
                n = $urandom_range(1, 8);
                for (k = 0; k < n; k++)
                    send_req(mk_req(2'($urandom), 4'($urandom), 8'($urandom), 2'($urandom)),
                             0, none);
            end
            if ($urandom_range(0, 19) == 0)
                drain_requests();
        end

        drain_requests();
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
